// ===== sv/khc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_pkg: shared types and constants of the k-mer histogram counter
// command codes, job control word, back-end states and elaboration helpers
// ----------------------------------------------------------------------------
package khc_pkg;

  // default sizes
  localparam int DEF_MAX_WINDOW    = 6;
  localparam int DEF_ALPHABET_SIZE = 4;
  localparam int DEF_COUNT_BITS    = 32;

  // queue between front and back end, a power of two
  localparam int QUEUE_DEPTH = 4;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int AMOUNT_W = 8;
  localparam int QUERY_W  = 14;
  localparam int ENTRY_W  = 32;
  localparam int ACTIVE_W = 14;
  localparam int WLEN_W   = 3;
  localparam int LSET_W   = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] MISSING_CHAR = 8'h5F;
  localparam logic [BYTE_W-1:0] LOWER_A      = 8'h61;
  localparam logic [BYTE_W-1:0] LOWER_Z      = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

  localparam logic [WLEN_W-1:0] RESET_WINDOW_LENGTH = 3'd6;
  localparam logic [LSET_W-1:0] RESET_LETTER_SET    = 32'h5447_4341;  // "ACGT"

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_SET    = 1'b1;

  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 32'hFFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_SYMBOL = 2'd0,
    CMD_EOL    = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // control part of a queued job
  typedef struct packed {
    cmd_t cmd;
    logic out_of_range;
  } job_ctrl_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPDATE,
    ST_CLEAR
  } back_state_t;

  // number of table entries: base to the power of the window
  function automatic int table_depth(input int max_window, input int alphabet_size);
    int d;
    d = 1;
    for (int i = 0; i < max_window; i++) begin
      d = d * (alphabet_size + 1);
    end
    return d;
  endfunction

  function automatic int letters_held(input int alphabet_size);
    return (alphabet_size < 4) ? alphabet_size : 4;
  endfunction

endpackage

// ===== sv/khc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module khc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/khc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_front: command front end
// letter coding, window shift register, line fill and table index build
// ----------------------------------------------------------------------------
module khc_front
  import khc_pkg::*;
#(
  parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [BYTE_W-1:0]    symbol_byte,
  input  logic [QUERY_W-1:0]   query_index,
  input  logic [WLEN_W-1:0]    window_length,
  input  logic [LSET_W-1:0]    letter_set,
  output logic                 push,
  output job_ctrl_t            push_ctrl,
  output logic [$clog2(table_depth(MAX_WINDOW, ALPHABET_SIZE))-1:0] push_addr
);

  localparam int CODE_BASE = ALPHABET_SIZE + 1;
  localparam int CODE_W    = $clog2(CODE_BASE);
  localparam int DEPTH     = table_depth(MAX_WINDOW, ALPHABET_SIZE);
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int FILL_W    = $clog2(MAX_WINDOW + 1);
  localparam int LETTERS   = letters_held(ALPHABET_SIZE);

  logic [CODE_W-1:0] window_codes [MAX_WINDOW];
  logic [CODE_W-1:0] codes_next   [MAX_WINDOW];
  logic [FILL_W-1:0] line_fill;
  logic [FILL_W-1:0] line_fill_next;
  logic [FILL_W-1:0] k_eff;
  logic [BYTE_W-1:0] folded;
  logic [CODE_W-1:0] code_new;
  logic [ADDR_W-1:0] window_addr;
  cmd_t              cmd_in;

  assign cmd_in = cmd_t'(cmd);

  // fold case and look the byte up, first matching letter wins
  always_comb begin
    folded = (symbol_byte >= LOWER_A && symbol_byte <= LOWER_Z) ?
             symbol_byte - CASE_OFFSET : symbol_byte;
    code_new = '0;
    if (folded != MISSING_CHAR) begin
      for (int i = LETTERS - 1; i >= 0; i--) begin
        if (letter_set[8*i +: 8] == folded) begin
          code_new = CODE_W'(i + 1);
        end
      end
    end
  end

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_length == '0) begin
      k_eff = FILL_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      k_eff = FILL_W'(MAX_WINDOW);
    end else begin
      k_eff = FILL_W'(window_length);
    end
  end

  always_comb begin
    codes_next[0] = code_new;
    for (int i = 1; i < MAX_WINDOW; i++) begin
      codes_next[i] = window_codes[i-1];
    end
    line_fill_next = (line_fill < FILL_W'(MAX_WINDOW)) ? line_fill + FILL_W'(1) : line_fill;
  end

  // oldest code most significant
  always_comb begin
    window_addr = '0;
    for (int i = MAX_WINDOW - 1; i >= 0; i--) begin
      if (i < int'(k_eff)) begin
        window_addr = ADDR_W'(window_addr * ADDR_W'(CODE_BASE)) + ADDR_W'(codes_next[i]);
      end
    end
  end

  always_comb begin
    push                   = 1'b0;
    push_ctrl.cmd          = cmd_in;
    push_ctrl.out_of_range = 1'b0;
    push_addr              = window_addr;
    unique case (cmd_in)
      CMD_SYMBOL: begin
        push = accept && (line_fill_next >= k_eff);
      end
      CMD_EOL: begin
        push = 1'b0;
      end
      CMD_CLEAR: begin
        push = accept;
      end
      CMD_READ: begin
        push                   = accept;
        push_addr              = ADDR_W'(query_index);
        push_ctrl.out_of_range = (32'(query_index) >= 32'(DEPTH));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        window_codes[i] <= '0;
      end
    end else if (accept) begin
      if (cmd_in == CMD_SYMBOL) begin
        line_fill <= line_fill_next;
        for (int i = 0; i < MAX_WINDOW; i++) begin
          window_codes[i] <= codes_next[i];
        end
      end else if (cmd_in == CMD_EOL) begin
        line_fill <= '0;
      end
    end
  end

endmodule

// ===== sv/khc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_queue: short job queue
// register-based first-in first-out buffer between front and back end
// ----------------------------------------------------------------------------
module khc_queue
  import khc_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PTR_W:0]   wr_ptr;
  logic [PTR_W:0]   rd_ptr;

  assign empty     = (wr_ptr == rd_ptr);
  assign full      = (wr_ptr[PTR_W] != rd_ptr[PTR_W]) &&
                     (wr_ptr[PTR_W-1:0] == rd_ptr[PTR_W-1:0]);
  assign head_data = slots[rd_ptr[PTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + (PTR_W+1)'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr[PTR_W-1:0]] <= push_data;
    end
  end

endmodule

// ===== sv/khc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// khc_back: table back end
// read-modify-write of counts, clear sweep, reads and non-zero tally
// ----------------------------------------------------------------------------
module khc_back
  import khc_pkg::*;
#(
  parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  job_ctrl_t           job_ctrl,
  input  logic [$clog2(table_depth(MAX_WINDOW, ALPHABET_SIZE))-1:0] job_addr,
  input  logic [AMOUNT_W-1:0] job_amount,
  output logic                pop,
  output logic                init_busy,
  output logic                result_valid,
  output logic [ENTRY_W-1:0]  entry_count,
  output logic [ACTIVE_W-1:0] active_windows
);

  localparam int DEPTH  = table_depth(MAX_WINDOW, ALPHABET_SIZE);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NZ_W   = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  back_state_t            state;
  back_state_t            state_next;
  logic [ADDR_W-1:0]      clr_addr;
  job_ctrl_t              cur_ctrl;
  logic [ADDR_W-1:0]      cur_addr;
  logic [AMOUNT_W-1:0]    cur_amount;
  logic [NZ_W-1:0]        nonzero;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [COUNT_BITS-1:0]  ram_wdata;
  logic [COUNT_BITS-1:0]  ram_rdata;
  logic [COUNT_BITS:0]    sum_wide;
  logic [COUNT_BITS-1:0]  sum;
  logic [ENTRY_W-1:0]     entry_sat;
  logic                   nz_inc;
  logic                   clr_start;
  logic                   res_fire;

  khc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (job_addr),
    .rd_data (ram_rdata)
  );

  // saturating add and narrowing of the entry for readout
  always_comb begin
    sum_wide  = {1'b0, ram_rdata} + (COUNT_BITS+1)'(cur_amount);
    sum       = sum_wide[COUNT_BITS] ? '1 : sum_wide[COUNT_BITS-1:0];
    entry_sat = (ram_rdata > COUNT_BITS'(ENTRY_MAX)) ? ENTRY_MAX : ENTRY_W'(ram_rdata);
  end

  assign init_busy = (state == ST_INIT);

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    nz_inc     = 1'b0;
    clr_start  = 1'b0;
    res_fire   = 1'b0;
    unique case (state)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          pop = 1'b1;
          unique case (job_ctrl.cmd) inside
            CMD_CLEAR: begin
              clr_start  = 1'b1;
              state_next = ST_CLEAR;
            end
            CMD_SYMBOL, CMD_READ: begin
              state_next = ST_UPDATE;
            end
            CMD_EOL: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        if (cur_ctrl.cmd == CMD_SYMBOL) begin
          ram_we    = 1'b1;
          ram_waddr = cur_addr;
          ram_wdata = sum;
          nz_inc    = (ram_rdata == '0) && (sum != '0);
        end else begin
          res_fire = 1'b1;
        end
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      clr_addr     <= '0;
      nonzero      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_fire;
      if (clr_start) begin
        clr_addr <= '0;
      end else if (state == ST_INIT || state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (clr_start) begin
        nonzero <= '0;
      end else if (nz_inc) begin
        nonzero <= nonzero + NZ_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ctrl   <= job_ctrl;
      cur_addr   <= job_addr;
      cur_amount <= job_amount;
    end
    if (res_fire) begin
      entry_count    <= cur_ctrl.out_of_range ? '0 : entry_sat;
      active_windows <= ACTIVE_W'(nonzero);
    end
  end

endmodule

// ===== sv/kmer_histogram_counter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_histogram_counter_unit: k-mer counting histogram
// counts every window of k letters of a byte stream in a table of counts
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low. A symbol word or
// a read word passes through the back end as a table read, then a write or
// a result. End of line is finished in the front end and never enters the
// queue. A clear walks the table one entry a cycle. After reset the table
// is swept to zero the same way, and busy stays high until the sweep is
// done. A four-deep job queue lets the front end keep taking words while
// the back end works; busy rises when it is full. A read result shows on
// entry_count and active_windows for exactly one cycle with result_valid
// high, and the receiver cannot stall it, so it must take it in that
// cycle. Results come out in command order. Configuration is written with
// cfg_write only while no command is pending in the unit; the unit itself
// does not enforce this.
// ----------------------------------------------------------------------------
module kmer_histogram_counter_unit
  import khc_pkg::*;
#(
  parameter int MAX_WINDOW    = DEF_MAX_WINDOW,
  parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  // command side
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [BYTE_W-1:0]    symbol_byte,
  input  logic [AMOUNT_W-1:0]  add_amount,
  input  logic [QUERY_W-1:0]   query_index,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LSET_W-1:0]    cfg_data,
  // results
  output logic                 result_valid,
  output logic [ENTRY_W-1:0]   entry_count,
  output logic [ACTIVE_W-1:0]  active_windows
);

  localparam int DEPTH  = table_depth(MAX_WINDOW, ALPHABET_SIZE);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int JOB_W  = $bits(job_ctrl_t) + ADDR_W + AMOUNT_W;

  // configuration registers
  logic [WLEN_W-1:0] window_length;
  logic [LSET_W-1:0] letter_set;

  // front end to queue
  logic              accept;
  logic              push;
  job_ctrl_t         push_ctrl;
  logic [ADDR_W-1:0] push_addr;

  // queue to back end
  logic [JOB_W-1:0]    head_data;
  logic                q_empty;
  logic                q_full;
  logic                pop;
  job_ctrl_t           job_ctrl;
  logic [ADDR_W-1:0]   job_addr;
  logic [AMOUNT_W-1:0] job_amount;
  logic                init_busy;

  // no word is taken while the queue is full or the reset sweep runs
  assign busy   = q_full || init_busy;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= RESET_WINDOW_LENGTH;
      letter_set    <= RESET_LETTER_SET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_W-1:0];
        CFG_LETTER_SET:    letter_set    <= cfg_data;
      endcase
    end
  end

  khc_front #(
    .MAX_WINDOW    (MAX_WINDOW),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .symbol_byte   (symbol_byte),
    .query_index   (query_index),
    .window_length (window_length),
    .letter_set    (letter_set),
    .push          (push),
    .push_ctrl     (push_ctrl),
    .push_addr     (push_addr)
  );

  // job word: control, table address, amount to add
  khc_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ctrl, push_addr, add_amount}),
    .pop       (pop),
    .head_data (head_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign {job_ctrl, job_addr, job_amount} = head_data;

  khc_back #(
    .MAX_WINDOW    (MAX_WINDOW),
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .COUNT_BITS    (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (!q_empty),
    .job_ctrl       (job_ctrl),
    .job_addr       (job_addr),
    .job_amount     (job_amount),
    .pop            (pop),
    .init_busy      (init_busy),
    .result_valid   (result_valid),
    .entry_count    (entry_count),
    .active_windows (active_windows)
  );

endmodule
